// File: src/length_prefixed_frame_deframer_macros.svh
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high.
`define LPFD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lpfd check failed");

// Property checked on every rising clock edge, reset included.
`define LPFD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("lpfd check failed");

`endif

// File: src/lpfd_pkg.sv
`timescale 1ns / 1ps

package lpfd_pkg;

   typedef enum logic [2:0] {
      PH_OVL     = 3'd0,
      PH_TYPE    = 3'd1,
      PH_PLEN    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC     = 3'd4,
      PH_SKIP    = 3'd5
   } phase_type;

   localparam logic        KIND_DATA   = 1'b0;
   localparam logic        KIND_STATUS = 1'b1;

   localparam logic [1:0]  STAT_OK      = 2'd0;
   localparam logic [1:0]  STAT_CRC_ERR = 2'd1;
   localparam logic [1:0]  STAT_LEN_ERR = 2'd2;

   localparam logic [31:0] OVL_BYTES      = 32'd4;
   localparam logic [31:0] TYPE_END_BYTES = 32'd6;
   localparam logic [31:0] HDR_BYTES      = 32'd10;
   localparam logic [31:0] FRAME_OVERHEAD = 32'd12;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h8408;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [7:0]        data;
      logic signed [15:0] frame_type;
      logic [1:0]        status;
   } result_type;

   function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: src/lpfd_parser.sv
`timescale 1ns / 1ps

module lpfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           in_byte,
   output lpfd_pkg::result_type result
);
   import lpfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] ovl_ff, ovl_in;
   logic [31:0] plen_ff, plen_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;

   logic [31:0] cnt_inc;
   logic [31:0] plen_shift;
   logic [15:0] rx_crc_shift;
   logic        hdr_done;
   logic        fits;
   logic        payload_done;
   logic        crc_done;
   logic        crc_match;
   logic        skip_more;
   logic        skip_done;
   logic        restart;

   assign cnt_inc      = count_ff + 32'd1;
   assign plen_shift   = {plen_ff[23:0], in_byte};
   assign rx_crc_shift = {rx_crc_ff[7:0], in_byte};
   assign hdr_done     = cnt_inc >= HDR_BYTES;
   assign fits         = !ovl_ff[31] && (ovl_ff >= FRAME_OVERHEAD) && !plen_shift[31]
                         && (plen_shift <= (ovl_ff - FRAME_OVERHEAD));
   assign payload_done = cnt_inc >= (HDR_BYTES + plen_ff);
   assign crc_done     = cnt_inc >= (FRAME_OVERHEAD + plen_ff);
   assign crc_match    = (crc_ff ^ CRC_INIT) == rx_crc_shift;
   assign skip_more    = !ovl_ff[31] && (cnt_inc < ovl_ff);
   assign skip_done    = cnt_inc >= ovl_ff;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_OVL: begin
            if (cnt_inc >= OVL_BYTES) phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            if (cnt_inc >= TYPE_END_BYTES) phase_in = PH_PLEN;
         end
         PH_PLEN: begin
            if (hdr_done) begin
               if (!fits) begin
                  phase_in = skip_more ? PH_SKIP : PH_OVL;
               end else begin
                  phase_in = (plen_shift == 32'd0) ? PH_CRC : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (payload_done) phase_in = PH_CRC;
         end
         PH_CRC: begin
            if (crc_done) phase_in = skip_more ? PH_SKIP : PH_OVL;
         end
         PH_SKIP: begin
            if (skip_done) phase_in = PH_OVL;
         end
         default: begin
            phase_in = PH_OVL;
         end
      endcase
   end

   assign restart = (phase_in == PH_OVL) && (phase_ff != PH_OVL);

   always_comb begin
      ovl_in    = ovl_ff;
      plen_in   = plen_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      result    = '0;
      unique case (phase_ff)
         PH_OVL: begin
            ovl_in = {ovl_ff[23:0], in_byte};
         end
         PH_TYPE: begin
            type_in = {type_ff[7:0], in_byte};
         end
         PH_PLEN: begin
            plen_in = plen_shift;
            if (hdr_done && !fits) begin
               result.valid      = 1'b1;
               result.kind       = KIND_STATUS;
               result.frame_type = type_ff;
               result.status     = STAT_LEN_ERR;
            end
         end
         PH_PAYLOAD: begin
            crc_in       = crc_x25_byte(crc_ff, in_byte);
            result.valid = 1'b1;
            result.kind  = KIND_DATA;
            result.data  = in_byte;
         end
         PH_CRC: begin
            rx_crc_in = rx_crc_shift;
            if (crc_done) begin
               result.valid      = 1'b1;
               result.kind       = KIND_STATUS;
               result.frame_type = type_ff;
               result.status     = crc_match ? STAT_OK : STAT_CRC_ERR;
            end
         end
         default: begin
         end
      endcase
      count_in = cnt_inc;
      if (restart) begin
         count_in = 32'd0;
         crc_in   = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OVL;
         count_ff  <= 32'd0;
         ovl_ff    <= 32'd0;
         plen_ff   <= 32'd0;
         type_ff   <= 16'd0;
         crc_ff    <= CRC_INIT;
         rx_crc_ff <= 16'd0;
      end else if (take) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         ovl_ff    <= ovl_in;
         plen_ff   <= plen_in;
         type_ff   <= type_in;
         crc_ff    <= crc_in;
         rx_crc_ff <= rx_crc_in;
      end
   end

endmodule

// File: src/lpfd_out_reg.sv
`timescale 1ns / 1ps

module lpfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lpfd_pkg::result_type result,
   output logic                 in_ready,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic                 out_kind,
   output logic [7:0]           out_byte,
   output logic signed [15:0]   out_frame_type,
   output logic [1:0]           out_frame_status
);
   import lpfd_pkg::*;

   logic               valid_ff;
   logic               kind_ff;
   logic [7:0]         byte_ff;
   logic signed [15:0] type_ff;
   logic [1:0]         status_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= result.valid;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         kind_ff   <= result.kind;
         byte_ff   <= result.data;
         type_ff   <= result.frame_type;
         status_ff <= result.status;
      end
   end

   assign out_valid        = valid_ff;
   assign out_kind         = kind_ff;
   assign out_byte         = byte_ff;
   assign out_frame_type   = type_ff;
   assign out_frame_status = status_ff;

endmodule

// File: src/length_prefixed_frame_deframer.sv
`timescale 1ns / 1ps
// A result is registered and appears on the rsp_ side in the cycle after its byte transfer.
// Throughput: one byte per cycle while rsp_ready does not hold a result back; the parser
// state and the bytewise CRC update are computed combinationally, and the result register
// takes a new result while the old one is being taken.
// Reset: synchronous, active high; parser returns to awaiting the overall length.

module length_prefixed_frame_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_out_kind,
   output logic [7:0]         rsp_out_byte,
   output logic signed [15:0] rsp_frame_type,
   output logic [1:0]         rsp_frame_status
);
   import lpfd_pkg::*;

   result_type result;
   logic       take;

   assign take = req_valid && req_ready;

   lpfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .result  (result)
   );

   lpfd_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (take),
      .result           (result),
      .in_ready         (req_ready),
      .out_ready        (rsp_ready),
      .out_valid        (rsp_valid),
      .out_kind         (rsp_out_kind),
      .out_byte         (rsp_out_byte),
      .out_frame_type   (rsp_frame_type),
      .out_frame_status (rsp_frame_status)
   );

endmodule

// File: src/lpfd_checker.sv
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_in_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_out_kind,
   input logic [7:0]         rsp_out_byte,
   input logic signed [15:0] rsp_frame_type,
   input logic [1:0]         rsp_frame_status
);

   `LPFD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid)
   `LPFD_ASSERT(a_hold_stalled, rsp_valid && !rsp_ready |=> rsp_valid)
   `LPFD_ASSERT(a_rise_needs_transfer, $rose(rsp_valid) |-> $past(req_valid && req_ready))
   `LPFD_ASSERT(a_data_fields_zero, rsp_valid && !rsp_out_kind |-> rsp_frame_type == 16'sd0 && rsp_frame_status == 2'd0)
   `LPFD_ASSERT(a_status_code, rsp_valid |-> rsp_frame_status != 2'd3)

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

// File: verif/length_prefixed_frame_deframer_tb.sv
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_tb;
   import lpfd_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [7:0]         data;
      logic signed [15:0] ftype;
      logic [1:0]         status;
   } deframe_result_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TARGET_BYTES   = 500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_in_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_out_kind;
   logic [7:0]         rsp_out_byte;
   logic signed [15:0] rsp_frame_type;
   logic [1:0]         rsp_frame_status;

   logic [7:0]         pending_bytes[$];
   deframe_result_type expected_results[$];

   phase_type          parse_state = PH_OVL;
   logic [31:0]        frame_bytes = 32'd0;
   logic [31:0]        overall_len = 32'd0;
   logic [31:0]        payload_len = 32'd0;
   logic [15:0]        type_word = 16'd0;
   logic [15:0]        running_crc = CRC_INIT;
   logic [15:0]        received_crc = 16'd0;

   int                 mismatch_count = 0;
   int                 bytes_sent = 0;
   int                 results_seen = 0;
   int                 idle_cycles = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   logic [6:0]         tx_idle_pct;
   logic [6:0]         rx_idle_pct;

   assign tx_idle_pct = (bytes_sent < 180) ? 7'd28 : (bytes_sent < 360) ? 7'd54 : 7'd0;
   assign rx_idle_pct = (bytes_sent < 180) ? 7'd54 : (bytes_sent < 360) ? 7'd28 : 7'd0;

   length_prefixed_frame_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_status (rsp_frame_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'd0, b};
      repeat (8) begin
         acc = acc[0] ? ((acc >> 1) ^ 16'h8408) : (acc >> 1);
      end
      return acc;
   endfunction

   function automatic bit frame_fits(input logic [31:0] ovl, input logic [31:0] plen);
      return !ovl[31] && ovl >= FRAME_OVERHEAD && !plen[31] && plen <= ovl - FRAME_OVERHEAD;
   endfunction

   function automatic void restart_frame();
      parse_state = PH_OVL;
      frame_bytes = 32'd0;
      running_crc = CRC_INIT;
   endfunction

   function automatic void close_frame(input logic [1:0] code);
      deframe_result_type r;
      r.kind   = KIND_STATUS;
      r.data   = 8'd0;
      r.ftype  = type_word;
      r.status = code;
      expected_results.push_back(r);
      if (!overall_len[31] && frame_bytes < overall_len) begin
         parse_state = PH_SKIP;
      end else begin
         restart_frame();
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      deframe_result_type r;
      frame_bytes = frame_bytes + 32'd1;
      case (parse_state)
         PH_OVL: begin
            overall_len = {overall_len[23:0], b};
            if (frame_bytes >= OVL_BYTES) parse_state = PH_TYPE;
         end
         PH_TYPE: begin
            type_word = {type_word[7:0], b};
            if (frame_bytes >= TYPE_END_BYTES) parse_state = PH_PLEN;
         end
         PH_PLEN: begin
            payload_len = {payload_len[23:0], b};
            if (frame_bytes >= HDR_BYTES) begin
               if (!frame_fits(overall_len, payload_len)) begin
                  close_frame(STAT_LEN_ERR);
               end else begin
                  parse_state = (payload_len == 32'd0) ? PH_CRC : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            running_crc = x25_update(running_crc, b);
            r.kind   = KIND_DATA;
            r.data   = b;
            r.ftype  = 16'sd0;
            r.status = STAT_OK;
            expected_results.push_back(r);
            if (frame_bytes >= HDR_BYTES + payload_len) parse_state = PH_CRC;
         end
         PH_CRC: begin
            received_crc = {received_crc[7:0], b};
            if (frame_bytes >= FRAME_OVERHEAD + payload_len) begin
               close_frame((~running_crc == received_crc) ? STAT_OK : STAT_CRC_ERR);
            end
         end
         PH_SKIP: begin
            if (frame_bytes >= overall_len) restart_frame();
         end
         default: begin
            restart_frame();
         end
      endcase
   endfunction

   task automatic push_frame(input logic [31:0] ovl, input logic [15:0] ftype,
                             input logic [31:0] plen, input bit corrupt);
      logic [15:0] crc;
      logic [7:0]  b;
      logic [31:0] tail;
      for (int i = 3; i >= 0; i--) pending_bytes.push_back(ovl[8*i +: 8]);
      pending_bytes.push_back(ftype[15:8]);
      pending_bytes.push_back(ftype[7:0]);
      for (int i = 3; i >= 0; i--) pending_bytes.push_back(plen[8*i +: 8]);
      if (frame_fits(ovl, plen)) begin
         crc = CRC_INIT;
         for (int unsigned i = 0; i < plen; i++) begin
            b = 8'($urandom_range(0, 255));
            crc = x25_update(crc, b);
            pending_bytes.push_back(b);
         end
         crc = ~crc;
         if (corrupt) crc = crc ^ (16'h1 << $urandom_range(0, 15));
         pending_bytes.push_back(crc[15:8]);
         pending_bytes.push_back(crc[7:0]);
         tail = ovl - FRAME_OVERHEAD - plen;
      end else begin
         tail = (!ovl[31] && ovl > HDR_BYTES) ? ovl - HDR_BYTES : 32'd0;
      end
      repeat (tail) pending_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // driver: advance to the next byte once the current transfer completes
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) deframe_byte(req_in_byte);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_valid   <= 1'b1;
               req_in_byte <= pending_bytes.pop_front();
               bytes_sent  <= bytes_sent + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: hold off once for a long stretch so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 40) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      deframe_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, kind", {31'd0, rsp_out_kind}, 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_out_kind !== want.kind) begin
               report_mismatch("out_kind", {31'd0, rsp_out_kind}, {31'd0, want.kind});
            end
            if (rsp_out_byte !== want.data) begin
               report_mismatch("out_byte", {24'd0, rsp_out_byte}, {24'd0, want.data});
            end
            if (rsp_frame_type !== want.ftype) begin
               report_mismatch("frame_type", {16'd0, rsp_frame_type}, {16'd0, want.ftype});
            end
            if (rsp_frame_status !== want.status) begin
               report_mismatch("frame_status", {30'd0, rsp_frame_status},
                               {30'd0, want.status});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] ovl;
      logic [31:0] plen;
      int          k;
      int          pick;

      // zero overall length: length error, next frame follows at once
      push_frame(32'd0, 16'h7FFF, 32'd0, 1'b0);
      push_frame(32'd13, 16'h8000, 32'd1, 1'b0);

      while (pending_bytes.size() < TARGET_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5 || pick == 9) begin
            plen = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 40);
            ovl  = FRAME_OVERHEAD + plen;
            if ($urandom_range(0, 3) == 0) ovl = ovl + $urandom_range(1, 4);
            push_frame(ovl, 16'($urandom_range(0, 65535)), plen,
                       pick == 9 || $urandom_range(0, 4) == 0);
         end else if (pick == 6) begin
            push_frame($urandom_range(0, 11), 16'($urandom_range(0, 65535)), $urandom(),
                       1'b0);
         end else if (pick == 7) begin
            push_frame($urandom() | 32'h8000_0000, 16'($urandom_range(0, 65535)), $urandom(),
                       1'b0);
         end else begin
            k   = $urandom_range(0, 6);
            ovl = FRAME_OVERHEAD + k;
            case ($urandom_range(0, 2))
               0: plen = k + 1 + $urandom_range(0, 3);
               1: plen = $urandom() | 32'h8000_0000;
               default: plen = ($urandom() & 32'h7FFF_FFFF) | 32'h0100_0000;
            endcase
            push_frame(ovl, 16'($urandom_range(0, 65535)), plen, 1'b0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/lpfd_pkg.sv
src/lpfd_parser.sv
src/lpfd_out_reg.sv
src/length_prefixed_frame_deframer.sv
src/lpfd_checker.sv
verif/length_prefixed_frame_deframer_tb.sv
